// ----- hdl/pu32_pkg.sv -----
// shared types, constants and color conversion for the palette upscaler
package pu32_pkg;

  localparam int unsigned FUNC_W    = 1;
  localparam int unsigned ENTRY_W   = 6;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned DEST_X_W  = 8;
  localparam int unsigned DEST_Y_W  = 9;
  localparam int unsigned VOFF_W    = 7;
  localparam int unsigned POS_W     = 8;

  localparam logic [VOFF_W-1:0] VOFF_RESET = 7'd52;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_PAL_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL     = 1'b1;

  // one source pixel waiting to be expanded into panel pixels
  typedef struct packed {
    logic [DEST_X_W-1:0] x0;
    logic [DEST_Y_W-1:0] y0;
    logic                wide;      // even column, two panel columns
    logic                tall;      // even row, two panel rows
    logic                no_entry;  // index beyond the palette, color is zero
  } pu32_item_t;

  // rgb555 to byte-swapped rgb565, green widened by repeating its top bit
  function automatic logic [COLOR_W-1:0] to_wire(input logic [COLOR_W-1:0] c);
    logic [4:0]         r;
    logic [4:0]         g;
    logic [4:0]         b;
    logic [COLOR_W-1:0] rgb565;
    r      = c[4:0];
    g      = c[9:5];
    b      = c[14:10];
    rgb565 = {r, g, g[4], b};
    return {rgb565[7:0], rgb565[15:8]};
  endfunction

endpackage

// ----- hdl/pu32_in_if.sv -----
// request channel: palette writes and source pixels
interface pu32_in_if import pu32_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ENTRY_W-1:0]  pal_entry;
  logic [COLOR_W-1:0]  pal_color;
  logic [INDEX_W-1:0]  pixel_index;
  logic                frame_start;

  modport source (
    output valid, func, pal_entry, pal_color, pixel_index, frame_start,
    input  ready
  );
  modport sink (
    input  valid, func, pal_entry, pal_color, pixel_index, frame_start,
    output ready
  );
endinterface

// ----- hdl/pu32_out_if.sv -----
// result channel: panel pixels with coordinates
interface pu32_out_if import pu32_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEST_X_W-1:0] dest_x;
  logic [DEST_Y_W-1:0] dest_y;
  logic [COLOR_W-1:0]  wire_color;
  logic                last;

  modport source (
    output valid, dest_x, dest_y, wire_color, last,
    input  ready
  );
  modport sink (
    input  valid, dest_x, dest_y, wire_color, last,
    output ready
  );
endinterface

// ----- hdl/pu32_ram.sv -----
// generic single-write, single-read ram with registered read data
module pu32_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pu32_front.sv -----
// request decode, raster position tracking, palette store and item register
module pu32_front import pu32_pkg::*; #(
  parameter int unsigned SRC_WIDTH       = 160,
  parameter int unsigned SRC_HEIGHT      = 144,
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pu32_in_if.sink            req_i,
  input  logic [VOFF_W-1:0]  voff_i,
  input  logic               take_i,
  output logic               item_valid_o,
  output pu32_item_t         item_o,
  output logic [COLOR_W-1:0] color_o
);

  localparam int unsigned     AW     = $clog2(PALETTE_ENTRIES);
  localparam logic [POS_W-1:0] COLS  = POS_W'(SRC_WIDTH);
  localparam logic [POS_W-1:0] ROWS  = POS_W'(SRC_HEIGHT);
  localparam logic [ENTRY_W:0] NENT  = (ENTRY_W+1)'(PALETTE_ENTRIES);

  logic             accept;
  logic             pal_we;
  logic             pix_re;
  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [POS_W-1:0] col_cur, row_cur;
  logic [POS_W-1:0] col_inc, row_inc;
  logic [8:0]       x_full;
  logic [9:0]       y_full;
  logic             valid_q, valid_d;
  pu32_item_t       item_q, item_d;

  assign req_i.ready = !valid_q || take_i;
  assign accept      = req_i.valid && req_i.ready;
  assign pal_we = accept && (req_i.func == FUNC_PAL_WRITE)
                  && ({1'b0, req_i.pal_entry} < NENT);
  assign pix_re = accept && (req_i.func == FUNC_PIXEL);

  // frame start restarts the raster at the top left
  assign col_cur = req_i.frame_start ? '0 : col_q;
  assign row_cur = req_i.frame_start ? '0 : row_q;
  assign col_inc = col_cur + POS_W'(1);
  assign row_inc = row_cur + POS_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_re) begin
      if (col_inc >= COLS) begin
        col_d = '0;
        row_d = (row_inc >= ROWS) ? '0 : row_inc;
      end else begin
        col_d = col_inc;
        row_d = row_cur;
      end
    end
  end

  // first panel coordinate: 3*(s/2) plus 2 for odd s, plus voff_i for rows
  assign x_full = ({2'b0, col_cur[7:1]} << 1) + {2'b0, col_cur[7:1]}
                  + {7'b0, col_cur[0], 1'b0};
  assign y_full = ({3'b0, row_cur[7:1]} << 1) + {3'b0, row_cur[7:1]}
                  + {8'b0, row_cur[0], 1'b0} + {3'b0, voff_i};

  always_comb begin
    item_d          = item_q;
    item_d.x0       = x_full[DEST_X_W-1:0];
    item_d.y0       = y_full[DEST_Y_W-1:0];
    item_d.wide     = !col_cur[0];
    item_d.tall     = !row_cur[0];
    item_d.no_entry = {1'b0, req_i.pixel_index[ENTRY_W-1:0]} >= NENT;
  end

  always_comb begin
    valid_d = valid_q;
    if (pix_re) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_re) begin
      item_q <= item_d;
    end
  end

  pu32_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (req_i.pal_entry[AW-1:0]),
    .wdata_i (to_wire(req_i.pal_color)),
    .re_i    (pix_re),
    .raddr_i (req_i.pixel_index[AW-1:0]),
    .rdata_o (color_o)
  );

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COLS) && (row_q < ROWS))
    else $error("raster position outside the source frame");

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("item consumed while none is held");

endmodule

// ----- hdl/pu32_emit.sv -----
// expands one held source pixel into 1, 2 or 4 panel pixels via the output register
module pu32_emit import pu32_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  pu32_item_t         item_i,
  input  logic [COLOR_W-1:0] color_i,
  output logic               take_o,
  pu32_out_if.source         res_o
);

  logic                dx, dy;
  logic                last_x, last_y, last_w;
  logic                load;
  logic [1:0]          sub_q, sub_d;
  logic                out_valid_q, out_valid_d;
  logic [DEST_X_W-1:0] dest_x_q;
  logic [DEST_Y_W-1:0] dest_y_q;
  logic [COLOR_W-1:0]  color_q;
  logic                last_q;

  // sub_q holds {dy, dx} of the next panel pixel, row-major order
  assign dx     = sub_q[0];
  assign dy     = sub_q[1];
  assign last_x = !item_i.wide || dx;
  assign last_y = !item_i.tall || dy;
  assign last_w = last_x && last_y;

  assign load   = item_valid_i && (!out_valid_q || res_o.ready);
  assign take_o = load && last_w;

  always_comb begin
    sub_d = sub_q;
    if (load) begin
      if (last_w) begin
        sub_d = 2'b00;
      end else if (last_x) begin
        sub_d = 2'b10;
      end else begin
        sub_d = {dy, 1'b1};
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dest_x_q <= item_i.x0 + {{(DEST_X_W-1){1'b0}}, dx};
      dest_y_q <= item_i.y0 + {{(DEST_Y_W-1){1'b0}}, dy};
      color_q  <= item_i.no_entry ? '0 : color_i;
      last_q   <= last_w;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.dest_x     = dest_x_q;
  assign res_o.dest_y     = dest_y_q;
  assign res_o.wire_color = color_q;
  assign res_o.last       = last_q;

  a_idle_sub_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_i |-> (sub_q == 2'b00))
    else $error("sub-pixel count not at start without a held item");

  a_last_marks_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (last_q == $past(take_o)))
    else $error("last flag disagrees with item release");

endmodule

// ----- hdl/palette_upscale_3_2.sv -----
// top level of the palette lookup and 3:2 nearest-neighbor upscaler
//
// a request either writes a palette entry (rgb555 in, stored as byte-swapped
// rgb565 with green widened by repeating its top bit) or delivers one source
// pixel index in raster order over a SRC_WIDTH x SRC_HEIGHT frame; frame_start
// restarts the raster at the top left. each source pixel becomes 1, 2 or 4
// panel pixels (even columns and even rows are doubled), sent row-major with
// dest_x, dest_y and the palette color, last set on the final one. the single
// output register sends one panel pixel per cycle while res_o.ready is high;
// the next request is taken in the cycle the current pixel's final panel
// pixel is loaded. a pixel request passes the palette ram read, then the
// output register, on its way to its first panel pixel. read an entry only
// after writing it. vertical_offset must be written only while idle, by the
// user; the block itself does not enforce it.
module palette_upscale_3_2 import pu32_pkg::*; #(
  parameter int unsigned SRC_WIDTH       = 160,
  parameter int unsigned SRC_HEIGHT      = 144,
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pu32_in_if.sink           req_i,
  pu32_out_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic [VOFF_W-1:0] cfg_wdata_i
);

  // vertical offset register, panel row of the first scaled row
  logic [VOFF_W-1:0]  voff_q;
  logic               item_valid;
  pu32_item_t         item;
  logic [COLOR_W-1:0] color;
  logic               take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voff_q <= VOFF_RESET;
    end else if (cfg_we_i) begin
      voff_q <= cfg_wdata_i;
    end
  end

  // decode, position tracking and palette lookup
  pu32_front #(
    .SRC_WIDTH       (SRC_WIDTH),
    .SRC_HEIGHT      (SRC_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .voff_i       (voff_q),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item),
    .color_o      (color)
  );

  // expansion into panel pixels
  pu32_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .color_i      (color),
    .take_o       (take),
    .res_o        (res_o)
  );

endmodule

// ----- dv/tb_palette_upscale_3_2.sv -----
// testbench for the palette upscaler: predicts panel pixels and checks them in order
module tb_palette_upscale_3_2;
  import pu32_pkg::*;

  localparam int unsigned SRC_W      = 160;
  localparam int unsigned SRC_H      = 144;
  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned LONG_HOLD  = 60;
  localparam int unsigned SETTLE     = 6;
  localparam int unsigned MAX_WAIT   = 9;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry;
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] index;
    logic               fstart;
  } request_t;

  typedef struct {
    logic [DEST_X_W-1:0] x;
    logic [DEST_Y_W-1:0] y;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } panel_px_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [VOFF_W-1:0] cfg_wdata;

  pu32_in_if  req_if ();
  pu32_out_if res_if ();

  palette_upscale_3_2 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state
  logic [COLOR_W-1:0] wire_palette [ENTRIES];
  int unsigned        src_col;
  int unsigned        src_row;
  logic [VOFF_W-1:0]  row_offset;

  request_t    pending_reqs [$];
  panel_px_t   panel_expect [$];
  request_t    cur_req;
  bit [63:0]   stim_written;
  bit          idle_on;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned hold_cnt;
  int unsigned results_seen;
  int unsigned errors;

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // rgb555 -> rgb565 with green top bit repeated, then bytes swapped for the wire
  function automatic logic [COLOR_W-1:0] wire_of(input logic [COLOR_W-1:0] rgb555);
    logic [COLOR_W-1:0] rgb565;
    rgb565 = {rgb555[4:0], rgb555[9:5], rgb555[9], rgb555[14:10]};
    return {rgb565[7:0], rgb565[15:8]};
  endfunction

  task automatic apply_request(input request_t rq);
    int unsigned x0;
    int unsigned y0;
    int unsigned nx;
    int unsigned ny;
    panel_px_t   px;
    if (rq.func == FUNC_PAL_WRITE) begin
      wire_palette[rq.entry] = wire_of(rq.color);
    end else begin
      if (rq.fstart) begin
        src_col = 0;
        src_row = 0;
      end
      // even positions cover two panel lines, odd ones a single line
      x0 = 3 * (src_col / 2) + ((src_col % 2) ? 2 : 0);
      y0 = row_offset + 3 * (src_row / 2) + ((src_row % 2) ? 2 : 0);
      nx = (src_col % 2) ? 1 : 2;
      ny = (src_row % 2) ? 1 : 2;
      for (int unsigned dy = 0; dy < ny; dy++) begin
        for (int unsigned dx = 0; dx < nx; dx++) begin
          px.x     = DEST_X_W'(x0 + dx);
          px.y     = DEST_Y_W'(y0 + dy);
          px.color = wire_palette[rq.index[ENTRY_W-1:0]];
          px.last  = (dy + 1 == ny) && (dx + 1 == nx);
          panel_expect.push_back(px);
        end
      end
      src_col++;
      if (src_col >= SRC_W) begin
        src_col = 0;
        src_row++;
        if (src_row >= SRC_H) src_row = 0;
      end
    end
  endtask

  task automatic queue_write(input logic [ENTRY_W-1:0] entry, input logic [COLOR_W-1:0] color,
                             input logic fstart);
    request_t rq;
    rq.func   = FUNC_PAL_WRITE;
    rq.entry  = entry;
    rq.color  = color;
    rq.index  = INDEX_W'($urandom);
    rq.fstart = fstart;
    stim_written[entry] = 1'b1;
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_pixel(input logic [INDEX_W-1:0] index, input logic fstart);
    request_t rq;
    rq.func   = FUNC_PIXEL;
    rq.entry  = ENTRY_W'($urandom);
    rq.color  = COLOR_W'($urandom);
    rq.index  = index;
    rq.fstart = fstart;
    pending_reqs.push_back(rq);
  endtask

  // random pixel that only ever reads an entry already written
  task automatic queue_random_pixel(input logic fstart);
    logic [ENTRY_W-1:0] e;
    logic [INDEX_W-1:0] idx;
    do e = ENTRY_W'($urandom_range(0, ENTRIES - 1)); while (!stim_written[e]);
    idx = INDEX_W'($urandom);
    idx[ENTRY_W-1:0] = e;
    queue_pixel(idx, fstart);
  endtask

  task automatic random_burst(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_write(ENTRY_W'($urandom_range(0, ENTRIES - 1)), COLOR_W'($urandom),
                    1'($urandom));
      end else begin
        queue_random_pixel($urandom_range(0, 31) == 0);
      end
    end
  endtask

  // sender holds back until every request is through and every panel pixel is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || panel_expect.size() != 0);
  endtask

  task automatic set_offset(input logic [VOFF_W-1:0] v);
    // palette writes leave no result, so let the pipeline settle first
    repeat (SETTLE) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    row_offset  = v;
    @(negedge clk_i);
  endtask

  task automatic report(input string field, input logic [COLOR_W-1:0] want,
                        input logic [COLOR_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) apply_request(cur_req);
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0) begin
          req_if.valid <= 1'b0;
          send_wait    <= send_wait - 1;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_if.valid       <= 1'b1;
          req_if.func        <= cur_req.func;
          req_if.pal_entry   <= cur_req.entry;
          req_if.pal_color   <= cur_req.color;
          req_if.pixel_index <= cur_req.index;
          req_if.frame_start <= cur_req.fstart;
          send_wait          <= idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // panel pixel monitor and receiver stalls
  always @(posedge clk_i) begin : monitor
    int unsigned wait_nxt;
    int unsigned hold_nxt;
    panel_px_t   want;
    if (rst_ni) begin
      wait_nxt = recv_wait;
      hold_nxt = hold_cnt;
      if (hold_nxt != 0) hold_nxt--;
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (panel_expect.size() == 0) begin
          $display("%0t: unexpected panel pixel, expected none, actual x=%0d y=%0d color=%0h",
                   $time, res_if.dest_x, res_if.dest_y, res_if.wire_color);
          errors++;
        end else begin
          want = panel_expect.pop_front();
          if (res_if.dest_x !== want.x) report("dest_x", want.x, res_if.dest_x);
          if (res_if.dest_y !== want.y) report("dest_y", want.y, res_if.dest_y);
          if (res_if.wire_color !== want.color) report("wire_color", want.color,
                                                        res_if.wire_color);
          if (res_if.last !== want.last) report("last", want.last, res_if.last);
        end
        wait_nxt = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        // long back-pressure so the block fills up and stalls its input
        if (results_seen == 40 || results_seen == 400) hold_nxt = LONG_HOLD;
      end else if (wait_nxt != 0) begin
        wait_nxt--;
      end
      recv_wait    <= wait_nxt;
      hold_cnt     <= hold_nxt;
      res_if.ready <= (wait_nxt == 0) && (hold_nxt == 0);
    end
  end

  initial begin : sequencer
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_PAL_WRITE;
    req_if.pal_entry   = '0;
    req_if.pal_color   = '0;
    req_if.pixel_index = '0;
    req_if.frame_start = 1'b0;
    res_if.ready       = 1'b0;
    for (int i = 0; i < ENTRIES; i++) wire_palette[i] = '0;
    src_col      = 0;
    src_row      = 0;
    row_offset   = VOFF_RESET;
    stim_written = '0;
    idle_on      = 1'b1;
    send_wait    = 0;
    recv_wait    = 0;
    hold_cnt     = 0;
    results_seen = 0;
    errors       = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset offset
    queue_write(6'd0, 16'h0000, 1'b1);   // frame_start on a write is ignored
    queue_write(6'd63, 16'hFFFF, 1'b0);  // all ones, bit 15 dropped
    queue_write(6'd31, 16'h01E0, 1'b0);  // green top bit clear
    queue_write(6'd32, 16'h0200, 1'b1);  // green top bit set
    queue_write(6'd1, 16'h801F, 1'b0);   // red only with bit 15 set
    queue_write(6'd62, 16'h7C00, 1'b0);  // blue only
    queue_pixel(8'h00, 1'b1);            // even column, even row: four pixels
    queue_pixel(8'hFF, 1'b0);            // upper index bits ignored
    queue_pixel(8'hDF, 1'b0);
    queue_pixel(8'h60, 1'b0);
    queue_pixel(8'h81, 1'b0);
    queue_pixel(8'h3E, 1'b0);
    queue_write(6'd0, 16'h5555, 1'b0);   // overwrite an entry
    queue_pixel(8'h40, 1'b0);
    queue_pixel(8'h00, 1'b1);            // restart mid-row
    queue_pixel(8'h3F, 1'b0);
    drain();

    set_offset(7'd0);
    random_burst(40);
    drain();

    // one full row at full rate: the row wrap into an odd row
    set_offset(7'd104);
    idle_on = 1'b0;
    queue_random_pixel(1'b1);
    for (int unsigned i = 1; i < SRC_W + 10; i++) queue_random_pixel(1'b0);
    drain();
    idle_on = 1'b1;

    set_offset(7'd127);
    random_burst(20);
    drain();

    set_offset(VOFF_W'($urandom_range(0, 104)));
    random_burst(15);
    drain();

    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 100000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pu32_pkg.sv
hdl/pu32_in_if.sv
hdl/pu32_out_if.sv
hdl/pu32_ram.sv
hdl/pu32_front.sv
hdl/pu32_emit.sv
hdl/palette_upscale_3_2.sv
dv/tb_palette_upscale_3_2.sv
